// ----- hw/rtl/nearest_palette_index_search_unit_assert.svh -----
// assertion macros shared by the checker
`ifndef NEAREST_PALETTE_INDEX_SEARCH_UNIT_ASSERT_SVH
`define NEAREST_PALETTE_INDEX_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define NPIS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NPIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/npis_pkg.sv -----
// shared types and constants for the nearest palette index search unit
package npis_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int WORD_W                  = 32;
   localparam int PIXEL_W                 = 24;
   localparam int SLOT_W                  = 8;
   localparam int RESULT_W                = 8;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic sample_valid;
   } scan_ctl_type;

endpackage

// ----- hw/rtl/npis_best_unit.sv -----
// shared distance and compare unit, keeps the running best palette index
module npis_best_unit #(
   parameter int IDX_W = 8
) (
   input  logic                              clock,
   input  npis_pkg::scan_ctl_type            ctl,
   input  logic [npis_pkg::WORD_W-1:0]       pixel,
   input  logic [npis_pkg::WORD_W-1:0]       entry,
   input  logic [IDX_W-1:0]                  sample_idx,
   output logic [IDX_W-1:0]                  best_idx
);

   logic [npis_pkg::WORD_W-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]            best_idx_ff, best_idx_in;
   logic [npis_pkg::WORD_W-1:0] abs_diff;

   assign abs_diff = (pixel > entry) ? (pixel - entry) : (entry - pixel);

   always_comb begin
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (ctl.clear) begin
         best_dist_in = '1;
         best_idx_in  = '0;
      end else if (ctl.sample_valid && (abs_diff < best_dist_ff)) begin
         best_dist_in = abs_diff;
         best_idx_in  = sample_idx;
      end
   end

   always_ff @(posedge clock) begin
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   assign best_idx = best_idx_ff;

endmodule

// ----- hw/rtl/nearest_palette_index_search_unit.sv -----
// nearest palette index search: palette memory, scan sequencer and result register
// Usage:
//   req channel: one beat per item. req_action low loads req_entry_color into
//   palette slot req_entry_index (slots at or above PALETTE_ENTRIES are dropped).
//   req_action high classifies req_pixel_color against the whole palette.
//   rsp channel: one beat per pixel with rsp_nearest_index (lowest index on a
//   tie) and rsp_run_done, the echo of req_last_pixel. Loads give no beat.
//   Every palette slot must be loaded before the first pixel.
// Timing:
//   loads are taken while the sequencer is idle, so they stream back to back.
//   a pixel is scanned from its accept to its result beat: one subtract-and-compare
//   unit visits one palette entry per cycle behind the registered memory read port.
//   req_stall is high through the scan, ST_LAST and ST_EMIT.
//   the next item is taken while a result still waits in the output register;
//   a stalled result holds the block only when the next result is ready.
// Reset: synchronous, clears the sequencer and the output valid; the palette
//   keeps no reset value.
module nearest_palette_index_search_unit #(
   parameter int PALETTE_ENTRIES = npis_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_action,
   input  logic [npis_pkg::SLOT_W-1:0]      req_entry_index,
   input  logic [npis_pkg::WORD_W-1:0]      req_entry_color,
   input  logic [npis_pkg::PIXEL_W-1:0]     req_pixel_color,
   input  logic                             req_last_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [npis_pkg::RESULT_W-1:0]    rsp_nearest_index,
   output logic                             rsp_run_done
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);

   npis_pkg::state_type state_ff, state_in;

   logic [npis_pkg::WORD_W-1:0] palette_mem [PALETTE_ENTRIES];
   logic [npis_pkg::WORD_W-1:0] rd_data_ff;

   logic [IDX_W-1:0]            addr_ff, addr_in;
   logic [IDX_W-1:0]            sample_idx_ff;
   logic                        sample_valid_ff, sample_valid_in;
   logic [npis_pkg::WORD_W-1:0] pixel_ff;
   logic                        last_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [npis_pkg::RESULT_W-1:0] rsp_index_ff;
   logic                        rsp_done_ff;

   logic                        req_fire, load_fire, pixel_fire, slot_ok;
   logic                        rd_en, emit, out_free;
   logic [IDX_W-1:0]            best_idx;
   npis_pkg::scan_ctl_type      ctl;

   assign req_fire   = req_valid && !req_stall;
   assign load_fire  = req_fire && (req_action == npis_pkg::ACTION_LOAD);
   assign pixel_fire = req_fire && (req_action == npis_pkg::ACTION_PIXEL);
   assign slot_ok    = (32'(req_entry_index) < 32'(PALETTE_ENTRIES));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npis_pkg::ST_IDLE: begin
            if (pixel_fire) state_in = npis_pkg::ST_SCAN;
         end
         npis_pkg::ST_SCAN: begin
            if (addr_ff == LAST_ADDR) state_in = npis_pkg::ST_LAST;
         end
         npis_pkg::ST_LAST: begin
            state_in = npis_pkg::ST_EMIT;
         end
         npis_pkg::ST_EMIT: begin
            if (out_free) state_in = npis_pkg::ST_IDLE;
         end
         default: state_in = npis_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         npis_pkg::ST_IDLE: req_stall = 1'b0;
         npis_pkg::ST_SCAN: rd_en = 1'b1;
         npis_pkg::ST_LAST: rd_en = 1'b0;
         npis_pkg::ST_EMIT: emit = out_free;
         default:           req_stall = 1'b1;
      endcase
   end

   assign addr_in         = pixel_fire ? '0 : (rd_en ? addr_ff + IDX_W'(1) : addr_ff);
   assign sample_valid_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= npis_pkg::ST_IDLE;
         sample_valid_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sample_valid_ff <= sample_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      sample_idx_ff <= addr_ff;
      if (pixel_fire) begin
         pixel_ff <= npis_pkg::WORD_W'(req_pixel_color);
         last_ff  <= req_last_pixel;
      end
   end

   // palette memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (load_fire && slot_ok) palette_mem[IDX_W'(req_entry_index)] <= req_entry_color;
      if (rd_en) rd_data_ff <= palette_mem[addr_ff];
   end

   always_comb begin
      ctl.clear        = pixel_fire;
      ctl.sample_valid = sample_valid_ff;
   end

   npis_best_unit #(
      .IDX_W (IDX_W)
   ) u_best (
      .clock      (clock),
      .ctl        (ctl),
      .pixel      (pixel_ff),
      .entry      (rd_data_ff),
      .sample_idx (sample_idx_ff),
      .best_idx   (best_idx)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_index_ff <= npis_pkg::RESULT_W'(best_idx);
         rsp_done_ff  <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_run_done      = rsp_done_ff;

endmodule

// ----- hw/rtl/npis_checker.sv -----
// port-level checker for the nearest palette index search unit, with its bind
`include "nearest_palette_index_search_unit_assert.svh"

module npis_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_action,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [npis_pkg::RESULT_W-1:0] rsp_nearest_index,
   input logic                          rsp_run_done
);

   logic pixel_beat;
   assign pixel_beat = req_valid && !req_stall && (req_action == npis_pkg::ACTION_PIXEL);

   `NPIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_nearest_index) && $stable(rsp_run_done), "stalled result beat changed")

   `NPIS_ASSERT_NEXT(a_busy_after_pixel, clock, reset, pixel_beat, req_stall, "request taken during a palette scan")

   `NPIS_ASSERT_NEXT(a_no_early_result, clock, reset, pixel_beat, ##1 !$rose(rsp_valid), "result beat before the scan could finish")

   `NPIS_ASSERT_IMPLY(a_reset_clears, clock, 1'b0, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind nearest_palette_index_search_unit npis_checker u_npis_checker (.*);
